/* hw/rtl/drm_pkg.sv */
`timescale 1ns / 1ps

package drm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int COORD_W  = 12;
    localparam int SIZE_W   = 13;
    localparam int END_W    = SIZE_W + 1;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 3;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FLUSHED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
    } box_t;

    localparam int BOX_W = $bits(box_t);

    typedef struct packed {
        logic                touch;
        box_t                bbox;
    } geom_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        box_t                box;
        logic                last;
    } res_t;

    typedef struct packed {
        logic              rd_en;
        logic [TBL_AW-1:0] rd_addr;
        logic              wr_en;
        logic [TBL_AW-1:0] wr_addr;
        box_t              wr_data;
    } mem_req_t;

endpackage

/* hw/rtl/drm_in_if.sv */
`timescale 1ns / 1ps

interface drm_in_if;
    import drm_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [COORD_W-1:0] rect_w;
    logic [COORD_W-1:0] rect_h;

    modport source (output valid, cmd, rect_x, rect_y, rect_w, rect_h, input ready);
    modport sink   (input valid, cmd, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

/* hw/rtl/drm_out_if.sv */
`timescale 1ns / 1ps

interface drm_out_if;
    import drm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COORD_W-1:0]  out_x;
    logic [COORD_W-1:0]  out_y;
    logic [SIZE_W-1:0]   out_w;
    logic [SIZE_W-1:0]   out_h;
    logic                last;

    modport source (output valid, status, slot, out_x, out_y, out_w, out_h, last,
                    input ready);
    modport sink   (input valid, status, slot, out_x, out_y, out_w, out_h, last,
                    output ready);
endinterface

/* hw/rtl/dirty_rectangle_merger_top.sv */
`timescale 1ns / 1ps

// Damage rectangle tracker with a 64-entry table held in one synchronous RAM.
// Channel req takes one word per command: cmd add brings rect_x/y/w/h, cmd flush
// ignores them. Channel rsp returns result words with status, slot, the
// rectangle and last; last marks the final word caused by a command.
// An add scans the stored entries one per cycle through the RAM read port and
// merges into the first entry it touches, or appends; on a full table the
// rectangle is dropped. A flush emits every entry in order (read, then load
// of the output register) and empties the table; an empty table gives one word.
// One command is worked on at a time; req.ready is high while the block is idle.
// The output register lets a new command be taken while the last word waits.
// When rsp stalls, the block holds its next word and stops until it is taken.
// Reset empties the table at once; the RAM contents are not cleared.
module dirty_rectangle_merger_top (
    input  logic      clk,
    input  logic      rst_n,
    drm_in_if.sink    req,
    drm_out_if.source rsp
);
    import drm_pkg::*;

    mem_req_t         mem;
    logic [BOX_W-1:0] rd_word;

    drm_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .mem     (mem),
        .rd_data (box_t'(rd_word))
    );

    drm_ram #(
        .WIDTH (BOX_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .rd_en   (mem.rd_en),
        .rd_addr (mem.rd_addr),
        .rd_data (rd_word),
        .wr_en   (mem.wr_en),
        .wr_addr (mem.wr_addr),
        .wr_data (mem.wr_data)
    );

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem.rd_en && mem.wr_en))
        else $error("table read and write issued in the same cycle");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("new command taken while one is still in progress");

    a_last_on_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_FLUSHED |-> rsp.last)
        else $error("single-word result without last");

    a_write_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem.wr_en |=> !req.ready)
        else $error("table write not followed by a result word");

endmodule

/* hw/rtl/drm_ram.sv */
`timescale 1ns / 1ps

module drm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/drm_geom.sv */
`timescale 1ns / 1ps

module drm_geom (
    input  drm_pkg::box_t  a,
    input  drm_pkg::box_t  b,
    output drm_pkg::geom_t res
);
    import drm_pkg::*;

    logic [END_W-1:0] ax, ay, bx, by;
    logic [END_W-1:0] a_right, a_bottom, b_right, b_bottom;
    logic [END_W-1:0] min_x, min_y, max_r, max_b;

    always_comb
    begin
        ax       = END_W'(a.x);
        ay       = END_W'(a.y);
        bx       = END_W'(b.x);
        by       = END_W'(b.y);
        a_right  = ax + END_W'(a.w);
        a_bottom = ay + END_W'(a.h);
        b_right  = bx + END_W'(b.w);
        b_bottom = by + END_W'(b.h);

        // Edges are inclusive, so rectangles that only touch count as overlapping.
        res.touch = (ax <= b_right) && (bx <= a_right) &&
                    (ay <= b_bottom) && (by <= a_bottom);

        min_x = (ax < bx) ? ax : bx;
        min_y = (ay < by) ? ay : by;
        max_r = (a_right > b_right) ? a_right : b_right;
        max_b = (a_bottom > b_bottom) ? a_bottom : b_bottom;

        res.bbox.x = COORD_W'(min_x);
        res.bbox.y = COORD_W'(min_y);
        res.bbox.w = SIZE_W'(max_r - min_x);
        res.bbox.h = SIZE_W'(max_b - min_y);
    end

endmodule

/* hw/rtl/drm_seq.sv */
`timescale 1ns / 1ps

module drm_seq (
    input  logic              clk,
    input  logic              rst_n,
    drm_in_if.sink            req,
    drm_out_if.source         rsp,
    output drm_pkg::mem_req_t mem,
    input  drm_pkg::box_t     rd_data
);
    import drm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_MERGE = 5'b00100,
        S_FLUSH = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [TBL_AW-1:0]   idx_reg, idx_next;
    box_t                item_reg, item_next;
    res_t                pend_reg, pend_next;
    res_t                out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    box_t                in_box;
    geom_t               geom;
    logic [COUNT_W-1:0]  idx_inc;
    logic                at_end;
    logic                out_free;

    drm_geom u_geom (
        .a   (item_reg),
        .b   (rd_data),
        .res (geom)
    );

    always_comb
    begin
        in_box.x = req.rect_x;
        in_box.y = req.rect_y;
        in_box.w = SIZE_W'(req.rect_w);
        in_box.h = SIZE_W'(req.rect_h);
        idx_inc  = COUNT_W'(idx_reg) + COUNT_W'(1);
        at_end   = (idx_inc == count_reg);
        out_free = !out_valid_reg || rsp.ready;
    end

    // A write is never issued in the same cycle as a read, and every later read
    // of the table comes in a later cycle than the write.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        item_next      = item_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem.rd_en      = 1'b0;
        mem.rd_addr    = idx_reg;
        mem.wr_en      = 1'b0;
        mem.wr_addr    = idx_reg;
        mem.wr_data    = item_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    item_next = in_box;
                    if (req.cmd == CMD_FLUSH)
                    begin
                        if (count_reg == '0)
                        begin
                            pend_next  = '{status: ST_EMPTY, slot: '0, box: '0, last: 1'b1};
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            mem.rd_en   = 1'b1;
                            mem.rd_addr = '0;
                            idx_next    = '0;
                            state_next  = S_FLUSH;
                        end
                    end
                    else if (count_reg == COUNT_W'(TABLE_DEPTH))
                    begin
                        pend_next  = '{status: ST_DROPPED, slot: '0, box: in_box, last: 1'b1};
                        state_next = S_EMIT;
                    end
                    else if (count_reg == '0)
                    begin
                        mem.wr_en   = 1'b1;
                        mem.wr_addr = '0;
                        mem.wr_data = in_box;
                        pend_next   = '{status: ST_APPENDED, slot: '0, box: in_box, last: 1'b1};
                        count_next  = COUNT_W'(1);
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = '0;
                        idx_next    = '0;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // The read for the next entry is issued while this one is compared;
                // on a hit it is held back so that the read data stays put.
                if (geom.touch)
                begin
                    state_next = S_MERGE;
                end
                else if (at_end)
                begin
                    mem.wr_en   = 1'b1;
                    mem.wr_addr = count_reg[TBL_AW-1:0];
                    mem.wr_data = item_reg;
                    pend_next   = '{status: ST_APPENDED, slot: SLOT_W'(count_reg),
                                    box: item_reg, last: 1'b1};
                    count_next  = count_reg + COUNT_W'(1);
                    state_next  = S_EMIT;
                end
                else
                begin
                    mem.rd_en   = 1'b1;
                    mem.rd_addr = idx_inc[TBL_AW-1:0];
                    idx_next    = idx_inc[TBL_AW-1:0];
                end
            end

            S_MERGE:
            begin
                mem.wr_en   = 1'b1;
                mem.wr_addr = idx_reg;
                mem.wr_data = geom.bbox;
                pend_next   = '{status: ST_MERGED, slot: SLOT_W'(idx_reg),
                                box: geom.bbox, last: 1'b1};
                state_next  = S_EMIT;
            end

            S_FLUSH:
            begin
                pend_next = '{status: ST_FLUSHED, slot: SLOT_W'(idx_reg),
                              box: rd_data, last: at_end};
                if (at_end)
                begin
                    count_next = '0;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    if (pend_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = idx_inc[TBL_AW-1:0];
                        idx_next    = idx_inc[TBL_AW-1:0];
                        state_next  = S_FLUSH;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        item_reg <= item_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_reg.status;
    assign rsp.slot   = out_reg.slot;
    assign rsp.out_x  = out_reg.box.x;
    assign rsp.out_y  = out_reg.box.y;
    assign rsp.out_w  = out_reg.box.w;
    assign rsp.out_h  = out_reg.box.h;
    assign rsp.last   = out_reg.last;

endmodule
